[sv/cwed_pkg.sv]
// ----------------------------------------------------------------------------
// cwed_pkg
// Shared types for the closest word edit distance block: the decoded command
// that travels from the front end through its queue to the back end.
// ----------------------------------------------------------------------------
package cwed_pkg;

  // Command codes. The values follow the kind field of an input item.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_QUERY = 2'd1,
    OP_CAND  = 2'd2,
    OP_END   = 2'd3
  } op_e_t;

  typedef struct packed {
    op_e_t      op;
    logic [7:0] byte_value;
    logic       last;
  } cmd_t;

  localparam int unsigned DIST_W = 7;
  localparam int unsigned INDEX_W = 8;

endpackage

[sv/cwed_ram.sv]
// ----------------------------------------------------------------------------
// cwed_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module cwed_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/cwed_front.sv]
// ----------------------------------------------------------------------------
// cwed_front
// Input side: takes items, decodes the kind into a command and keeps them in
// a two entry queue in front of the back end.
// ----------------------------------------------------------------------------
module cwed_front
  import cwed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_byte_value,
  input  logic       in_last_candidate,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_ready
);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PW = $clog2(QDEPTH);

  cmd_t              queue_r [QDEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]       count_r, count_nxt;
  cmd_t              dec;
  logic              push, pop;

  always_comb begin
    case (in_kind)
      2'd0:    dec.op = OP_START;
      2'd1:    dec.op = OP_QUERY;
      2'd2:    dec.op = OP_CAND;
      2'd3:    dec.op = OP_END;
      default: dec.op = OP_START;
    endcase
    dec.byte_value = in_byte_value;
    dec.last       = in_last_candidate;
  end

  assign in_ready  = (count_r != (PW+1)'(QDEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = queue_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= dec;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(QDEPTH))
    else $error("command queue count exceeds its depth");

  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == (PW+1)'(QDEPTH)) && !pop |=> count_r == (PW+1)'(QDEPTH))
    else $error("command queue lost an entry while full");

endmodule

[sv/cwed_back.sv]
// ----------------------------------------------------------------------------
// cwed_back
// Execution side: holds the query, the distance row and the running best.
// A candidate byte walks the row one query position per cycle through the
// row RAM; an end of candidate reads the last entry (unless the query is
// empty) and loads the result register.
// ----------------------------------------------------------------------------
module cwed_back
  import cwed_pkg::*;
#(
  parameter int unsigned MAX_LEN = 64,
  parameter int unsigned MAX_CANDIDATES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [INDEX_W-1:0] out_candidate_index,
  output logic [DIST_W-1:0]  out_candidate_distance,
  output logic [INDEX_W-1:0] out_best_index,
  output logic [DIST_W-1:0]  out_best_distance,
  output logic               out_is_final,
  output logic               out_length_overflow
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned CW = $clog2(MAX_CANDIDATES + 1);
  localparam int unsigned BW = $clog2(MAX_CANDIDATES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ENDRD,
    S_RESULT
  } state_t;

  state_t              state_r, state_nxt;
  logic [LW-1:0]       qlen_r, qlen_nxt;
  logic                qovf_r, qovf_nxt;
  logic [LW-1:0]       cand_len_r, cand_len_nxt;
  logic                cand_ovf_r, cand_ovf_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [BW-1:0]       best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0]   best_val_r, best_val_nxt;
  logic [MAX_LEN-1:0]  valid_r, valid_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [LW-1:0]       diag_r, diag_nxt;
  logic [LW-1:0]       left_r, left_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic [DIST_W-1:0]   dist_r, dist_nxt;
  logic                last_r, last_nxt;
  logic                vld_rd_r, vld_rd_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]  out_cidx_r, out_cidx_nxt;
  logic [DIST_W-1:0]   out_cdist_r, out_cdist_nxt;
  logic [INDEX_W-1:0]  out_bidx_r, out_bidx_nxt;
  logic [DIST_W-1:0]   out_bdist_r, out_bdist_nxt;
  logic                out_final_r, out_final_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic [AW-1:0]       raddr;
  logic                row_we;
  logic [LW-1:0]       row_wdata;
  logic [LW-1:0]       row_rdata;
  logic                q_we;
  logic [7:0]          q_rdata;

  logic [LW-1:0]       above;
  logic [LW:0]         up1, left1, sub, vmin;
  logic [LW-1:0]       vnew;

  function automatic logic [DIST_W-1:0] sat_dist(input logic [LW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'd127) ? DIST_W'(127) : w[DIST_W-1:0];
  endfunction

  cwed_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (idx_r),
    .wdata (row_wdata),
    .raddr (raddr),
    .rdata (row_rdata)
  );

  cwed_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_query_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (qlen_r[AW-1:0]),
    .wdata (cmd.byte_value),
    .raddr (raddr),
    .rdata (q_rdata)
  );

  // One row cell: entry j takes the least of above + 1, left + 1 and the
  // diagonal plus the substitution cost. An entry not yet written holds j + 1.
  always_comb begin
    above = vld_rd_r ? row_rdata : LW'(idx_r) + LW'(1);
    up1   = {1'b0, above} + (LW+1)'(1);
    left1 = {1'b0, left_r} + (LW+1)'(1);
    sub   = {1'b0, diag_r} + (LW+1)'(q_rdata != byte_r);
    vmin  = up1;
    if (left1 < vmin) begin
      vmin = left1;
    end
    if (sub < vmin) begin
      vmin = sub;
    end
    vnew = vmin[LW-1:0];
  end

  always_comb begin
    logic [31:0] cnt_ext;
    logic [31:0] best_ext;
    state_nxt     = state_r;
    qlen_nxt      = qlen_r;
    qovf_nxt      = qovf_r;
    cand_len_nxt  = cand_len_r;
    cand_ovf_nxt  = cand_ovf_r;
    count_nxt     = count_r;
    best_idx_nxt  = best_idx_r;
    best_val_nxt  = best_val_r;
    valid_nxt     = valid_r;
    idx_nxt       = idx_r;
    diag_nxt      = diag_r;
    left_nxt      = left_r;
    byte_nxt      = byte_r;
    dist_nxt      = dist_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_cidx_nxt  = out_cidx_r;
    out_cdist_nxt = out_cdist_r;
    out_bidx_nxt  = out_bidx_r;
    out_bdist_nxt = out_bdist_r;
    out_final_nxt = out_final_r;
    out_ovf_nxt   = out_ovf_r;
    cmd_ready     = 1'b0;
    raddr         = idx_r;
    row_we        = 1'b0;
    row_wdata     = vnew;
    q_we          = 1'b0;
    cnt_ext       = 32'(count_r);
    best_ext      = 32'(best_idx_r);

    case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        raddr     = '0;
        if (cmd_valid) begin
          case (cmd.op)
            OP_START: begin
              qlen_nxt     = '0;
              qovf_nxt     = 1'b0;
              valid_nxt    = '0;
              cand_len_nxt = '0;
              cand_ovf_nxt = 1'b0;
              count_nxt    = '0;
              best_idx_nxt = '0;
              best_val_nxt = DIST_W'(127);
            end
            OP_QUERY: begin
              if (qlen_r < LW'(MAX_LEN)) begin
                q_we     = 1'b1;
                qlen_nxt = qlen_r + LW'(1);
              end else begin
                qovf_nxt = 1'b1;
              end
              // A query byte abandons any candidate in progress.
              valid_nxt    = '0;
              cand_len_nxt = '0;
              cand_ovf_nxt = 1'b0;
            end
            OP_CAND: begin
              if (cand_len_r >= LW'(MAX_LEN)) begin
                cand_ovf_nxt = 1'b1;
              end else begin
                cand_len_nxt = cand_len_r + LW'(1);
                if (qlen_r != '0) begin
                  diag_nxt  = cand_len_r;
                  left_nxt  = cand_len_r + LW'(1);
                  byte_nxt  = cmd.byte_value;
                  idx_nxt   = '0;
                  state_nxt = S_SCAN;
                end
              end
            end
            OP_END: begin
              last_nxt = cmd.last;
              if (qlen_r == '0) begin
                dist_nxt  = sat_dist(cand_len_r);
                state_nxt = S_RESULT;
              end else begin
                raddr     = AW'(qlen_r - LW'(1));
                state_nxt = S_ENDRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        row_we          = 1'b1;
        valid_nxt[idx_r] = 1'b1;
        left_nxt        = vnew;
        diag_nxt        = above;
        if (idx_r == AW'(qlen_r - LW'(1))) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
          raddr   = idx_r + AW'(1);
        end
      end
      S_ENDRD: begin
        dist_nxt  = sat_dist(vld_rd_r ? row_rdata : qlen_r);
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          // Candidates past the count limit are reported but never win.
          if (count_r < CW'(MAX_CANDIDATES)) begin
            if ((count_r == '0) || (dist_r < best_val_r)) begin
              best_val_nxt = dist_r;
              best_idx_nxt = BW'(count_r);
            end
            count_nxt = count_r + CW'(1);
          end
          best_ext      = 32'(best_idx_nxt);
          out_valid_nxt = 1'b1;
          out_cidx_nxt  = cnt_ext[INDEX_W-1:0];
          out_cdist_nxt = dist_r;
          out_bidx_nxt  = best_ext[INDEX_W-1:0];
          out_bdist_nxt = best_val_nxt;
          out_final_nxt = last_r;
          out_ovf_nxt   = qovf_r || cand_ovf_r;
          valid_nxt     = '0;
          cand_len_nxt  = '0;
          cand_ovf_nxt  = 1'b0;
          if (last_r) begin
            count_nxt    = '0;
            best_idx_nxt = '0;
            best_val_nxt = DIST_W'(127);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    vld_rd_nxt = valid_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      qlen_r      <= '0;
      qovf_r      <= 1'b0;
      cand_len_r  <= '0;
      cand_ovf_r  <= 1'b0;
      count_r     <= '0;
      best_idx_r  <= '0;
      best_val_r  <= DIST_W'(127);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      qlen_r      <= qlen_nxt;
      qovf_r      <= qovf_nxt;
      cand_len_r  <= cand_len_nxt;
      cand_ovf_r  <= cand_ovf_nxt;
      count_r     <= count_nxt;
      best_idx_r  <= best_idx_nxt;
      best_val_r  <= best_val_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      diag_r      <= diag_nxt;
      left_r      <= left_nxt;
      byte_r      <= byte_nxt;
      dist_r      <= dist_nxt;
      last_r      <= last_nxt;
      vld_rd_r    <= vld_rd_nxt;
      out_cidx_r  <= out_cidx_nxt;
      out_cdist_r <= out_cdist_nxt;
      out_bidx_r  <= out_bidx_nxt;
      out_bdist_r <= out_bdist_nxt;
      out_final_r <= out_final_nxt;
      out_ovf_r   <= out_ovf_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_candidate_index    = out_cidx_r;
  assign out_candidate_distance = out_cdist_r;
  assign out_best_index         = out_bidx_r;
  assign out_best_distance      = out_bdist_r;
  assign out_is_final           = out_final_r;
  assign out_length_overflow    = out_ovf_r;

  a_qlen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qlen_r <= LW'(MAX_LEN))
    else $error("query length beyond the store");

  a_cand_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cand_len_r <= LW'(MAX_LEN))
    else $error("candidate length beyond the row");

  a_scan_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> (LW'(idx_r) < qlen_r) && (qlen_r != '0))
    else $error("row walk past the query length");

  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT) && out_valid_r && !out_ready |=> state_r == S_RESULT)
    else $error("result dropped while the output register was full");

endmodule

[sv/closest_word_edit_distance.sv]
// ----------------------------------------------------------------------------
// closest_word_edit_distance
// Levenshtein distance of a stored query word against a stream of candidates.
// ----------------------------------------------------------------------------
// Items enter a two entry command queue and are executed one at a time by the
// back end. A candidate byte walks the stored query through the row RAM, which
// is read and written once per query position. An end of candidate reads the
// last row entry (unless the query is empty) and then loads the output register
// as soon as it is free. The queue keeps taking items while the back end is
// busy or a result waits, as long as it is not full.
module closest_word_edit_distance
  import cwed_pkg::*;
#(
  parameter int unsigned MAX_LEN = 64,
  parameter int unsigned MAX_CANDIDATES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_byte_value,
  input  logic               in_last_candidate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [INDEX_W-1:0] out_candidate_index,
  output logic [DIST_W-1:0]  out_candidate_distance,
  output logic [INDEX_W-1:0] out_best_index,
  output logic [DIST_W-1:0]  out_best_distance,
  output logic               out_is_final,
  output logic               out_length_overflow
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  cwed_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_byte_value     (in_byte_value),
    .in_last_candidate (in_last_candidate),
    .cmd               (cmd),
    .cmd_valid         (cmd_valid),
    .cmd_ready         (cmd_ready)
  );

  cwed_back #(
    .MAX_LEN        (MAX_LEN),
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .cmd_valid              (cmd_valid),
    .cmd_ready              (cmd_ready),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_candidate_index    (out_candidate_index),
    .out_candidate_distance (out_candidate_distance),
    .out_best_index         (out_best_index),
    .out_best_distance      (out_best_distance),
    .out_is_final           (out_is_final),
    .out_length_overflow    (out_length_overflow)
  );

endmodule
